[hw/rtl/ucb_pkg.sv]
// ----------------------------------------------------------------------------
// ucb_pkg: shared types and constants of the universal code binarizer
// Holds the field widths, status and register codes, and the record that
// travels from the classifier to the symbol emitter.
// ----------------------------------------------------------------------------
package ucb_pkg;

	// Longest code that is sent as symbols; longer codes are flagged.
	localparam int MAX_RESULTS = 42;
	localparam int CODE_W      = MAX_RESULTS;
	localparam int LEN_W       = $clog2(MAX_RESULTS + 1);

	// Field widths of the channels and the configuration port.
	localparam int VAL_W    = 32;
	localparam int LIMIT_W  = 31;
	localparam int BC_W     = 6;
	localparam int MODE_W   = 2;
	localparam int SYM_W    = 16;
	localparam int STATUS_W = 2;
	localparam int CFG_IDX_W = 1;

	// Code selection.
	localparam logic [MODE_W-1:0] MODE_FIXED = 2'd0;
	localparam logic [MODE_W-1:0] MODE_GAMMA = 2'd1;
	localparam logic [MODE_W-1:0] MODE_DELTA = 2'd2;
	localparam logic [MODE_W-1:0] MODE_TRUNC = 2'd3;

	// Result status.
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_SYM = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_SYM  = 1'd1;

	// Depth of the queue between classifier and emitter.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// One classified item: a right-aligned code word, its length and status.
	typedef struct packed {
		logic [CODE_W-1:0]   bits;
		logic [LEN_W-1:0]    len;
		logic [STATUS_W-1:0] status;
	} ucb_entry_t;

endpackage

[hw/rtl/ucb_if.sv]
// ----------------------------------------------------------------------------
// ucb_if: channel interfaces of the universal code binarizer
// The item channel carries the value to encode, the code channel carries
// one emitted symbol per transfer.
// ----------------------------------------------------------------------------
interface ucb_item_if import ucb_pkg::*;;
	logic               valid;
	logic               ready;
	logic [MODE_W-1:0]  mode;
	logic [VAL_W-1:0]   value;
	logic [BC_W-1:0]    bit_count;
	logic [LIMIT_W-1:0] limit;

	modport source (output valid, mode, value, bit_count, limit, input ready);
	modport sink   (input valid, mode, value, bit_count, limit, output ready);
endinterface

interface ucb_code_if import ucb_pkg::*;;
	logic                valid;
	logic                ready;
	logic [SYM_W-1:0]    symbol;
	logic                last;
	logic [STATUS_W-1:0] status;

	modport source (output valid, symbol, last, status, input ready);
	modport sink   (input valid, symbol, last, status, output ready);
endinterface

[hw/rtl/ucb_front.sv]
// ----------------------------------------------------------------------------
// ucb_front: item classifier
// Two pipeline stages turn an accepted item into a right-aligned code word
// with its length, or into a flagged empty or out-of-range record.
// ----------------------------------------------------------------------------
module ucb_front import ucb_pkg::*; #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	ucb_item_if.sink   item,
	output logic       push,
	output ucb_entry_t push_entry,
	input  logic       full
);

	localparam logic [VAL_W-1:0] VMASK = (VALUE_WIDTH >= VAL_W) ? {VAL_W{1'b1}} :
		VAL_W'((64'd1 << VALUE_WIDTH) - 64'd1);

	// Number of significant bits of a word.
	function automatic logic [LEN_W-1:0] bit_len(input logic [VAL_W-1:0] x);
		logic [LEN_W-1:0] n;
		n = '0;
		for (int i = 0; i < VAL_W; i++) begin
			if (x[i]) n = LEN_W'(i + 1);
		end
		return n;
	endfunction

	logic               v_s1, v_s2;
	logic               s1_free, s2_free;
	logic [VAL_W-1:0]   val_in;

	logic [MODE_W-1:0]  mode_s1;
	logic [VAL_W-1:0]   val_s1;
	logic [BC_W-1:0]    bc_s1;
	logic [LEN_W-1:0]   nb_s1;
	logic [VAL_W-1:0]   span_s1;
	logic               over_s1;

	logic [MODE_W-1:0]  mode_s2;
	logic [VAL_W-1:0]   val_s2;
	logic [BC_W-1:0]    bc_s2;
	logic [LEN_W-1:0]   nb_s2;
	logic               over_s2;
	logic [LEN_W-1:0]   k_s2;
	logic [VAL_W-1:0]   u_s2;
	logic [CODE_W-1:0]  dword_s2;
	logic [LEN_W-1:0]   dlen_s2;

	logic [LEN_W-1:0]   k_nx;
	logic [VAL_W:0]     pow_nx;
	logic [LEN_W-1:0]   gb_nx;
	logic [LEN_W-1:0]   hb_nx;
	logic [CODE_W-1:0]  dword_nx;

	logic               below_u;
	logic [LEN_W-1:0]   tcount;
	logic [VAL_W-1:0]   tword;

	// Stall chain: a stage takes new data when it is empty or moves on.
	assign s2_free    = !v_s2 || !full;
	assign s1_free    = !v_s1 || s2_free;
	assign item.ready = s1_free;
	assign push       = v_s2 && !full;
	assign val_in     = item.value & VMASK;

	// Truncated-binary split point and delta code word, from stage one.
	always_comb begin
		k_nx     = bit_len(span_s1);
		pow_nx   = (VAL_W + 1)'(1) << k_nx;
		gb_nx    = bit_len(VAL_W'(nb_s1));
		hb_nx    = nb_s1 - LEN_W'(1);
		dword_nx = ((CODE_W'(nb_s1) << hb_nx) |
			(CODE_W'(val_s1) & ~(CODE_W'(1) << hb_nx)));
	end

	// Valid bits of both stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (s1_free) v_s1 <= item.valid;
			if (s2_free) v_s2 <= v_s1;
		end
	end

	// Stage payloads.
	always_ff @(posedge clk) begin
		if (s1_free && item.valid) begin
			mode_s1 <= item.mode;
			val_s1  <= val_in;
			bc_s1   <= item.bit_count;
			nb_s1   <= bit_len(val_in);
			span_s1 <= VAL_W'({1'b0, item.limit}) + VAL_W'(1);
			over_s1 <= val_in > VAL_W'({1'b0, item.limit});
		end
		if (s2_free && v_s1) begin
			mode_s2  <= mode_s1;
			val_s2   <= val_s1;
			bc_s2    <= bc_s1;
			nb_s2    <= nb_s1;
			over_s2  <= over_s1;
			k_s2     <= k_nx;
			u_s2     <= VAL_W'(pow_nx - {1'b0, span_s1});
			dword_s2 <= dword_nx;
			dlen_s2  <= LEN_W'({gb_nx, 1'b0} + nb_s1 - LEN_W'(2));
		end
	end

	// Final selection of code word, length and status.
	always_comb begin
		below_u = val_s2 < u_s2;
		tcount  = below_u ? (k_s2 - LEN_W'(1)) : k_s2;
		tword   = below_u ? val_s2 : (val_s2 + u_s2);

		push_entry.bits   = CODE_W'(val_s2);
		push_entry.len    = LEN_W'(bc_s2);
		push_entry.status = ST_OK;
		case (mode_s2)
			MODE_FIXED: begin
				if (bc_s2 == '0) push_entry.status = ST_EMPTY;
				else if (bc_s2 > BC_W'(MAX_RESULTS)) push_entry.status = ST_RANGE;
			end
			MODE_GAMMA: begin
				push_entry.len = LEN_W'({nb_s2, 1'b0} - 1);
				if (nb_s2 == '0) push_entry.status = ST_EMPTY;
				else if (nb_s2 > LEN_W'((MAX_RESULTS + 1) / 2)) push_entry.status = ST_RANGE;
			end
			MODE_DELTA: begin
				push_entry.bits = dword_s2;
				push_entry.len  = dlen_s2;
				if (nb_s2 == '0) push_entry.status = ST_EMPTY;
			end
			MODE_TRUNC: begin
				push_entry.bits = CODE_W'(tword);
				push_entry.len  = tcount;
				if (over_s2) push_entry.status = ST_RANGE;
				else if (tcount == '0) push_entry.status = ST_EMPTY;
			end
			default: push_entry.status = ST_RANGE;
		endcase
	end

endmodule

[hw/rtl/ucb_queue.sv]
// ----------------------------------------------------------------------------
// ucb_queue: short queue between classifier and emitter
// A small circular buffer of classified records, so that either side can
// stall without holding up the other.
// ----------------------------------------------------------------------------
module ucb_queue import ucb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  ucb_entry_t push_entry,
	output logic       full,
	input  logic       pop,
	output logic       nempty,
	output ucb_entry_t head
);

	ucb_entry_t          mem [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wptr_q, rptr_q;
	logic [QPTR_W:0]     count_q;

	assign full   = count_q == (QPTR_W + 1)'(QUEUE_DEPTH);
	assign nempty = count_q != '0;
	assign head   = mem[rptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + QPTR_W'(1);
			if (pop)  rptr_q <= rptr_q + QPTR_W'(1);
			if (push && !pop)      count_q <= count_q + (QPTR_W + 1)'(1);
			else if (pop && !push) count_q <= count_q - (QPTR_W + 1)'(1);
		end
	end

	// Record storage.
	always_ff @(posedge clk) begin
		if (push) mem[wptr_q] <= push_entry;
	end

`ifndef NO_ASSERTIONS
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("queue written while full");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> nempty) else $error("queue read while empty");
	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + (QPTR_W + 1)'(1))
		else $error("fill count lost a transfer");
`endif

endmodule

[hw/rtl/ucb_back.sv]
// ----------------------------------------------------------------------------
// ucb_back: symbol emitter
// Walks the head record's code word top bit first, one symbol per cycle unless
// stalled, into a registered output stage; also holds the symbol registers.
// ----------------------------------------------------------------------------
module ucb_back import ucb_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SYM_W-1:0]     cfg_data,
	input  logic                 nempty,
	input  ucb_entry_t           head,
	output logic                 pop,
	ucb_code_if.source           code
);

	logic [SYM_W-1:0]    zero_sym_q, one_sym_q;
	logic [LEN_W-1:0]    cnt_q;
	logic                ov_q;
	logic [SYM_W-1:0]    sym_q;
	logic                last_q;
	logic [STATUS_W-1:0] status_q;

	logic                load;
	logic [LEN_W-1:0]    rem;
	logic [LEN_W-1:0]    idx;
	logic                is_last;
	logic                cur_bit;

	// Position of the next bit and end-of-run detection.
	always_comb begin
		rem     = head.len - cnt_q;
		idx     = rem - LEN_W'(1);
		cur_bit = head.bits[idx];
		is_last = (head.status != ST_OK) || (rem == LEN_W'(1));
		load    = nempty && (!ov_q || code.ready);
		pop     = load && is_last;
	end

	assign code.valid  = ov_q;
	assign code.symbol = sym_q;
	assign code.last   = last_q;
	assign code.status = status_q;

	// Symbol registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_sym_q <= SYM_W'(0);
			one_sym_q  <= SYM_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ZERO_SYM: zero_sym_q <= cfg_data;
				REG_ONE_SYM:  one_sym_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Bit counter and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ov_q  <= 1'b0;
		end else begin
			if (load) begin
				ov_q  <= 1'b1;
				cnt_q <= is_last ? '0 : (cnt_q + LEN_W'(1));
			end else if (code.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (load) begin
			last_q   <= is_last;
			status_q <= head.status;
			if (head.status != ST_OK) sym_q <= '0;
			else sym_q <= cur_bit ? one_sym_q : zero_sym_q;
		end
	end

`ifndef NO_ASSERTIONS
	a_flag_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && status_q != ST_OK) |-> last_q) else $error("flagged result not last");
	a_cnt_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		(nempty && head.status == ST_OK) |-> cnt_q < head.len)
		else $error("bit counter past end of code");
	a_cnt_needs_head: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != '0) |-> nempty) else $error("run in progress without a record");
`endif

endmodule

[hw/rtl/universal_code_binarizer_core.sv]
// ----------------------------------------------------------------------------
// universal_code_binarizer_core: integer to binary-code symbol stream
// Encodes each item as fixed bits, Elias gamma, Elias delta or truncated
// binary and sends the code as symbol indices, most significant bit first.
// ----------------------------------------------------------------------------
// Usage:
//   item channel: one transfer per integer, with its mode, bit count and limit.
//   code channel: one transfer per symbol; last marks the end of a run. Empty
//     codes and out-of-range values give a single transfer with symbol 0,
//     last set and a nonzero status.
//   cfg port: cfg_we with cfg_index 0 sets the zero symbol, index 1 the one
//     symbol; write only while the block is idle.
// Path: an item passes the two classify stages, one queue slot and the output
//   register before its first symbol is valid.
// Throughput: the emitter sends one symbol per cycle while the receiver is
//   ready; an item gives 1 to 42 symbols. Items that give one symbol each
//   flow at one per cycle while the receiver is ready.
// Reset: clears all stages and the queue, zero symbol 0, one symbol 1.
// Stall: when the receiver holds ready low the output register keeps its
//   symbol; the queue fills, and the item channel drops ready once the
//   queue and both classify stages are full.
// ----------------------------------------------------------------------------
module universal_code_binarizer_core import ucb_pkg::*; #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SYM_W-1:0]     cfg_data,
	ucb_item_if.sink             item,
	ucb_code_if.source           code
);

	logic       push, full, pop, nempty;
	ucb_entry_t push_entry, head;

	// Classifier.
	ucb_front #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.push       (push),
		.push_entry (push_entry),
		.full       (full)
	);

	// Decoupling queue.
	ucb_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.pop        (pop),
		.nempty     (nempty),
		.head       (head)
	);

	// Symbol emitter.
	ucb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.nempty    (nempty),
		.head      (head),
		.pop       (pop),
		.code      (code)
	);

endmodule
